FILE: hw/rtl/sico_pkg.sv
// Package for the solution index canonical order block.
// Holds shared widths, the microcode control word and flag types, and the
// microprogram ROM. No dependencies.
package sico_pkg;

  localparam int unsigned LOG_SET_SIZE_DEF = 9;
  localparam int unsigned INDEX_BITS_DEF   = 21;
  localparam int unsigned VALUE_W          = 21;
  localparam int unsigned SWAP_W           = 9;
  localparam int unsigned STEP_W           = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    CondNext,
    CondAlways,
    CondNoSwap,
    CondKMore,
    CondBaseMore,
    CondLvlMore
  } cond_e;

  typedef struct packed {
    logic  init;
    logic  rd_head;
    logic  cmp;
    logic  rd_elem;
    logic  wr_a;
    logic  wr_b;
    logic  inc_k;
    logic  adv_base;
    logic  adv_lvl;
    logic  done;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic no_swap;
    logic k_more;
    logic base_more;
    logic lvl_more;
  } flags_t;

  localparam step_t StInit = 4'd0;
  localparam step_t StHead = 4'd1;
  localparam step_t StCmp  = 4'd2;
  localparam step_t StElem = 4'd3;
  localparam step_t StWrA  = 4'd4;
  localparam step_t StWrB  = 4'd5;
  localparam step_t StPair = 4'd6;
  localparam step_t StLvl  = 4'd7;
  localparam step_t StDone = 4'd8;

  // A step jumps to its target when its condition holds and falls through
  // to the next step otherwise.
  function automatic ctrl_t ucode_rom(step_t step);
    ctrl_t w;
    w        = '0;
    w.cond   = CondNext;
    w.target = StInit;
    case (step)
      StInit: w.init = 1'b1;
      StHead: w.rd_head = 1'b1;
      StCmp: begin
        w.cmp    = 1'b1;
        w.cond   = CondNoSwap;
        w.target = StPair;
      end
      StElem: w.rd_elem = 1'b1;
      StWrA:  w.wr_a = 1'b1;
      StWrB: begin
        w.wr_b   = 1'b1;
        w.inc_k  = 1'b1;
        w.cond   = CondKMore;
        w.target = StElem;
      end
      StPair: begin
        w.adv_base = 1'b1;
        w.cond     = CondBaseMore;
        w.target   = StHead;
      end
      StLvl: begin
        w.adv_lvl = 1'b1;
        w.cond    = CondLvlMore;
        w.target  = StHead;
      end
      StDone: w.done = 1'b1;
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/sico_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on sico_pkg.
module sico_seq import sico_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output logic   busy_o,
  output ctrl_t  ctrl_o
);

  step_t step_q;
  logic  busy_q;
  logic  jump;

  assign ctrl_o = busy_q ? ucode_rom(step_q) : '0;
  assign busy_o = busy_q;

  always_comb begin
    case (ctrl_o.cond)
      CondAlways:   jump = 1'b1;
      CondNoSwap:   jump = flags_i.no_swap;
      CondKMore:    jump = flags_i.k_more;
      CondBaseMore: jump = flags_i.base_more;
      CondLvlMore:  jump = flags_i.lvl_more;
      default:      jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StInit;
      busy_q <= 1'b0;
    end else if (start_i) begin
      step_q <= StInit;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (ctrl_o.done) begin
        busy_q <= 1'b0;
      end
      step_q <= jump ? ctrl_o.target : step_q + step_t'(1);
    end
  end

endmodule

FILE: hw/rtl/sico_dp.sv
// Ordering datapath: index store with two read ports and one write port,
// level, base and offset registers, compare and swap counter.
// Depends on sico_pkg.
module sico_dp import sico_pkg::*; #(
  parameter int unsigned LOG_SET_SIZE = LOG_SET_SIZE_DEF,
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output flags_t                  flags_o,
  output logic [SWAP_W-1:0]       swaps_o,
  input  logic                    host_we_i,
  input  logic                    host_re_i,
  input  logic [LOG_SET_SIZE-1:0] host_addr_i,
  input  logic [INDEX_BITS-1:0]   host_wdata_i,
  output logic [INDEX_BITS-1:0]   rdata_o
);

  localparam int unsigned SetSize = 1 << LOG_SET_SIZE;
  localparam int unsigned LvlW    = $clog2(LOG_SET_SIZE + 1);

  logic [INDEX_BITS-1:0]   mem [SetSize];
  logic [INDEX_BITS-1:0]   rd_a_q, rd_b_q;
  logic [LvlW-1:0]         lvl_q;
  logic [LOG_SET_SIZE-1:0] base_q, k_q;
  logic [SWAP_W-1:0]       swaps_q;

  logic [LOG_SET_SIZE-1:0] len, addr_a, addr_b, waddr, raddr_a;
  logic [LOG_SET_SIZE:0]   base_nxt;
  logic [INDEX_BITS-1:0]   wdata;
  logic                    we, re;

  assign len      = LOG_SET_SIZE'(1) << lvl_q;
  assign base_nxt = {1'b0, base_q} + {len, 1'b0};
  assign addr_a   = base_q + k_q;
  assign addr_b   = base_q + len + k_q;

  assign flags_o.no_swap   = rd_a_q < rd_b_q;
  assign flags_o.k_more    = k_q != (len - LOG_SET_SIZE'(1));
  assign flags_o.base_more = base_nxt != (LOG_SET_SIZE + 1)'(SetSize);
  assign flags_o.lvl_more  = lvl_q != LvlW'(LOG_SET_SIZE - 1);

  assign we      = host_we_i | ctrl_i.wr_a | ctrl_i.wr_b;
  assign waddr   = ctrl_i.wr_a ? addr_a : (ctrl_i.wr_b ? addr_b : host_addr_i);
  assign wdata   = ctrl_i.wr_a ? rd_b_q : (ctrl_i.wr_b ? rd_a_q : host_wdata_i);
  assign re      = host_re_i | ctrl_i.rd_head | ctrl_i.rd_elem;
  assign raddr_a = host_re_i ? host_addr_i : addr_a;

  assign rdata_o = rd_a_q;
  assign swaps_o = swaps_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_q <= mem[raddr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      base_q  <= '0;
      k_q     <= '0;
      swaps_q <= '0;
    end else begin
      if (ctrl_i.init) begin
        lvl_q   <= '0;
        base_q  <= '0;
        k_q     <= '0;
        swaps_q <= '0;
      end
      if (ctrl_i.cmp && !flags_o.no_swap) begin
        swaps_q <= swaps_q + SWAP_W'(1);
      end
      if (ctrl_i.inc_k) begin
        k_q <= k_q + LOG_SET_SIZE'(1);
      end
      if (ctrl_i.adv_base) begin
        base_q <= base_nxt[LOG_SET_SIZE-1:0];
        k_q    <= '0;
      end
      if (ctrl_i.adv_lvl) begin
        lvl_q <= lvl_q + LvlW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/solution_index_canonical_order.sv
// Load: one transfer per cycle while idle. Fetch: the transfer is read into the store's read
// register and moves the block to SFetch; the result register takes it once it is free, and
// no input is taken until then. After the last load the microprogram orders the set, each
// element swap being one dual read and two writes; no transfer is taken while it runs, nor
// in the SSort state that hands the set over.
// Reset clears counters, flags and the sequencer; store contents stay undefined.
module solution_index_canonical_order import sico_pkg::*; #(
  parameter int unsigned LOG_SET_SIZE = LOG_SET_SIZE_DEF,
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [VALUE_W-1:0] index_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ready_res_o,
  output logic [VALUE_W-1:0] out_value_o,
  output logic               is_last_o,
  output logic [SWAP_W-1:0]  swap_total_o
);

  localparam int unsigned SetSize = 1 << LOG_SET_SIZE;

  typedef enum logic [1:0] {SIdle, SFetch, SSort} state_e;

  state_e                  state_q;
  logic [LOG_SET_SIZE:0]   load_cnt_q;
  logic [LOG_SET_SIZE-1:0] rd_ptr_q;
  logic                    set_ready_q;
  logic                    pend_ok_q, pend_last_q;
  logic [SWAP_W-1:0]       pend_swap_q;
  logic                    out_valid_q, ready_res_q, is_last_q;
  logic [VALUE_W-1:0]      out_value_q;
  logic [SWAP_W-1:0]       swap_total_q;

  logic                    in_acc, load_acc, fetch_acc, last_load, last_fetch, out_free;
  logic                    seq_busy;
  logic [LOG_SET_SIZE-1:0] host_addr;
  logic [INDEX_BITS-1:0]   rdata;
  logic [SWAP_W-1:0]       swaps;
  ctrl_t                   ctrl;
  flags_t                  flags;

  assign in_ready_o = state_q == SIdle;
  assign in_acc     = in_valid_i & in_ready_o;
  assign load_acc   = in_acc & ~cmd_i & ~set_ready_q;
  assign fetch_acc  = in_acc & cmd_i;
  assign last_load  = load_cnt_q == (LOG_SET_SIZE + 1)'(SetSize - 1);
  assign last_fetch = rd_ptr_q == LOG_SET_SIZE'(SetSize - 1);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign host_addr  = set_ready_q ? rd_ptr_q : load_cnt_q[LOG_SET_SIZE-1:0];

  sico_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_acc & last_load),
    .flags_i (flags),
    .busy_o  (seq_busy),
    .ctrl_o  (ctrl)
  );

  sico_dp #(
    .LOG_SET_SIZE (LOG_SET_SIZE),
    .INDEX_BITS   (INDEX_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .swaps_o      (swaps),
    .host_we_i    (load_acc),
    .host_re_i    (fetch_acc & set_ready_q),
    .host_addr_i  (host_addr),
    .host_wdata_i (INDEX_BITS'(index_value_i)),
    .rdata_o      (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      load_cnt_q   <= '0;
      rd_ptr_q     <= '0;
      set_ready_q  <= 1'b0;
      pend_ok_q    <= 1'b0;
      pend_last_q  <= 1'b0;
      pend_swap_q  <= '0;
      out_valid_q  <= 1'b0;
      ready_res_q  <= 1'b0;
      is_last_q    <= 1'b0;
      out_value_q  <= '0;
      swap_total_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != SFetch) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (load_acc) begin
            load_cnt_q <= load_cnt_q + (LOG_SET_SIZE + 1)'(1);
            if (last_load) begin
              state_q <= SSort;
            end
          end
          if (fetch_acc) begin
            pend_ok_q   <= set_ready_q;
            pend_last_q <= set_ready_q & last_fetch;
            pend_swap_q <= set_ready_q ? swaps : '0;
            state_q     <= SFetch;
            if (set_ready_q) begin
              if (last_fetch) begin
                rd_ptr_q    <= '0;
                set_ready_q <= 1'b0;
                load_cnt_q  <= '0;
              end else begin
                rd_ptr_q <= rd_ptr_q + LOG_SET_SIZE'(1);
              end
            end
          end
        end
        SFetch: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            ready_res_q  <= pend_ok_q;
            out_value_q  <= pend_ok_q ? VALUE_W'(rdata) : '0;
            is_last_q    <= pend_last_q;
            swap_total_q <= pend_swap_q;
            state_q      <= SIdle;
          end
        end
        SSort: begin
          if (!seq_busy) begin
            set_ready_q <= 1'b1;
            rd_ptr_q    <= '0;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ready_res_o  = ready_res_q;
  assign out_value_o  = out_value_q;
  assign is_last_o    = is_last_q;
  assign swap_total_o = swap_total_q;

  a_busy_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy |-> state_q == SSort)
    else $error("Sequencer runs outside the ordering state.");

  a_last_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> ready_res_o)
    else $error("End of set flagged on a fetch without a ready set.");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(set_ready_q) |-> load_cnt_q == (LOG_SET_SIZE + 1)'(SetSize))
    else $error("Set marked ready before it was full.");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_acc && set_ready_q && last_fetch |=> !set_ready_q && load_cnt_q == '0)
    else $error("Block not emptied after the final fetch.");

endmodule

FILE: tb/sv/tb_solution_index_canonical_order.sv
// Self-checking testbench for solution_index_canonical_order: loads a whole index set,
// predicts the canonical tree order and swap count, and checks every fetch result.
// Depends on sico_pkg and the solution_index_canonical_order RTL.
module tb_solution_index_canonical_order;
  import sico_pkg::*;

  localparam int unsigned LOG_SET      = LOG_SET_SIZE_DEF;
  localparam int unsigned IDX_BITS     = INDEX_BITS_DEF;
  localparam int unsigned SET_SIZE     = 1 << LOG_SET;
  localparam logic [VALUE_W-1:0] IDX_MASK = VALUE_W'((64'd1 << IDX_BITS) - 1);
  localparam logic [VALUE_W-1:0] VAL_MAX  = '1;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned NOISE_PCT    = 4;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_e;

  typedef enum int {
    SET_NARROW,
    SET_WIDE,
    SET_FLAT
  } set_kind_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [VALUE_W-1:0] value;
  } stim_t;

  typedef struct packed {
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [SWAP_W-1:0]  swaps;
  } fetch_res_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               cmd_i         = 1'b0;
  logic [VALUE_W-1:0] index_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               ready_res_o;
  logic [VALUE_W-1:0] out_value_o;
  logic               is_last_o;
  logic [SWAP_W-1:0]  swap_total_o;

  stim_t       pending_q[$];
  fetch_res_t  expected_q[$];
  int unsigned n_items;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_ready    = 0;
  int unsigned n_errors   = 0;
  int unsigned hold_left  = 0;

  logic [VALUE_W-1:0] set_mem[SET_SIZE];
  int unsigned        fill_cnt = 0;
  int unsigned        rd_pos   = 0;
  int unsigned        swap_cnt = 0;
  bit                 set_full = 1'b0;

  solution_index_canonical_order #(
    .LOG_SET_SIZE(LOG_SET),
    .INDEX_BITS  (IDX_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .index_value_i(index_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ready_res_o  (ready_res_o),
    .out_value_o  (out_value_o),
    .is_last_o    (is_last_o),
    .swap_total_o (swap_total_o)
  );

  function automatic void tree_order_set();
    int unsigned        len;
    int unsigned        base;
    int unsigned        k;
    logic [VALUE_W-1:0] tmp;
    swap_cnt = 0;
    for (len = 1; len < SET_SIZE; len = len * 2) begin
      for (base = 0; base + 2 * len <= SET_SIZE; base += 2 * len) begin
        if (set_mem[base] >= set_mem[base + len]) begin
          for (k = 0; k < len; k++) begin
            tmp                 = set_mem[base + k];
            set_mem[base + k]   = set_mem[base + len + k];
            set_mem[base + len + k] = tmp;
          end
          swap_cnt++;
        end
      end
    end
  endfunction

  function automatic void apply_transfer(input logic op, input logic [VALUE_W-1:0] value);
    fetch_res_t res;
    if (op == CMD_LOAD) begin
      if (!set_full && fill_cnt < SET_SIZE) begin
        set_mem[fill_cnt] = value & IDX_MASK;
        fill_cnt++;
        if (fill_cnt == SET_SIZE) begin
          tree_order_set();
          rd_pos   = 0;
          set_full = 1'b1;
        end
      end
    end else begin
      res = '0;
      if (set_full) begin
        res.ready = 1'b1;
        res.value = set_mem[rd_pos];
        res.last  = (rd_pos == SET_SIZE - 1);
        res.swaps = swap_cnt[SWAP_W-1:0];
        rd_pos++;
        if (rd_pos == SET_SIZE) begin
          set_full = 1'b0;
          fill_cnt = 0;
          rd_pos   = 0;
          swap_cnt = 0;
        end
      end
      expected_q.insert(expected_q.size(), res);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (result %0d)",
                                name, got, want, n_results));
    end
  endtask

  task automatic queue_item(input cmd_e op, input logic [VALUE_W-1:0] value);
    stim_t it;
    it.cmd   = op;
    it.value = value;
    pending_q.insert(pending_q.size(), it);
  endtask

  // Queues the rest of one set: loads from first_load on (with stray fetches between them),
  // then the read-out fetches (with stray loads that the block must ignore), and at random one extra fetch.
  task automatic queue_set(input set_kind_e kind, input int unsigned first_load);
    logic [VALUE_W-1:0] flat_val;
    logic [VALUE_W-1:0] val;
    int unsigned        i;
    flat_val = VALUE_W'($urandom);
    for (i = first_load; i < SET_SIZE; i++) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        queue_item(CMD_FETCH, VALUE_W'($urandom));
      end
      case (kind)
        SET_NARROW: val = VALUE_W'($urandom_range(3));
        SET_WIDE:   val = VALUE_W'($urandom);
        default:    val = flat_val;
      endcase
      queue_item(CMD_LOAD, val);
    end
    for (i = 0; i < SET_SIZE; i++) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        queue_item(CMD_LOAD, VALUE_W'($urandom));
      end
      queue_item(CMD_FETCH, VALUE_W'($urandom));
    end
    if ($urandom_range(1) == 1) begin
      queue_item(CMD_FETCH, VALUE_W'($urandom));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bit    take;
    stim_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      take = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        apply_transfer(cmd_i, index_value_i);
        n_accepted++;
        take = 1'b1;
      end
      if (take) begin
        if (pending_q.size() > 0 &&
            ((n_accepted >= 600 && n_accepted < 900) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_q.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= nxt.cmd;
          index_value_i <= nxt.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    fetch_res_t got;
    fetch_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.ready = ready_res_o;
        got.value = out_value_o;
        got.last  = is_last_o;
        got.swaps = swap_total_o;
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    n_results));
        end else begin
          want = expected_q.pop_front();
          check_field("ready_res", int'(got.ready), int'(want.ready));
          check_field("out_value", int'(got.value), int'(want.value));
          check_field("is_last", int'(got.last), int'(want.last));
          check_field("swap_total", int'(got.swaps), int'(want.swaps));
        end
        if (got.ready) begin
          n_ready++;
          if (n_ready == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (n_results >= 200 && n_results < 400) ||
                       $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    // Directed opening: fetches on an empty block, load extremes and
    // alternating bit patterns, equal neighbours, and a fetch mid-set.
    queue_item(CMD_FETCH, VAL_MAX);
    queue_item(CMD_FETCH, '0);
    queue_item(CMD_LOAD, '0);
    queue_item(CMD_LOAD, VAL_MAX);
    queue_item(CMD_LOAD, VALUE_W'(21'h155555));
    queue_item(CMD_LOAD, VALUE_W'(21'h0AAAAA));
    queue_item(CMD_LOAD, VALUE_W'(7));
    queue_item(CMD_LOAD, VALUE_W'(7));
    queue_item(CMD_LOAD, VAL_MAX);
    queue_item(CMD_LOAD, VAL_MAX);
    queue_item(CMD_FETCH, VALUE_W'(21'h0AAAAA));
    queue_set(SET_NARROW, 8);
    n_items = pending_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
